[src/lvwb_pkg.sv]
package lvwb_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_ENTRIES_DEF = 8;
   localparam int ADDR_BITS_DEF   = 48;

   // Fixed access and line geometry
   localparam int MAX_ACCESS_BYTES = 64;
   localparam int BYTES_W          = 7;
   localparam int LG_W             = 3;
   localparam int LG_MIN           = 2;
   localparam int LG_MAX           = 7;
   localparam int OFF_W            = LG_MAX;
   localparam int SUM_W            = OFF_W + 1;
   localparam int CNT_W            = $clog2((MAX_ACCESS_BYTES + 2) / 4 + 1);
   localparam int STAT_W           = 32;

   // Configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 4;
   localparam int ENT_W      = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENTRIES_IN_USE = 4'd0,
      CSR_LINE_SIZE_LOG2 = 4'd1
   } lvwb_csr_idx_type;

   // Control part of one queued access
   typedef struct packed {
      logic             store;
      logic [CNT_W-1:0] lines_m1;
   } lvwb_job_ctl_type;

   // Handshake between front and back
   typedef struct packed {
      logic             valid;
      lvwb_job_ctl_type ctl;
   } lvwb_job_hs_type;

   function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
      sat_inc = (v == {STAT_W{1'b1}}) ? v : v + STAT_W'(1);
   endfunction

endpackage

[src/lvwb_front.sv]
module lvwb_front #(
   parameter int ADDR_BITS = lvwb_pkg::ADDR_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ADDR_BITS-1:0]                req_addr,
   input  logic [lvwb_pkg::BYTES_W-1:0]        req_access_bytes,
   input  logic                                req_func,
   input  logic [lvwb_pkg::LG_W-1:0]           lg_eff,
   output lvwb_pkg::lvwb_job_hs_type           job_hs,
   output logic [ADDR_BITS-lvwb_pkg::LG_MIN-1:0] job_tag,
   input  logic                                job_pop
);

   localparam int TAG_W = ADDR_BITS - lvwb_pkg::LG_MIN;

   logic [lvwb_pkg::BYTES_W-1:0] bytes_n;
   logic [lvwb_pkg::OFF_W-1:0]   off;
   logic [lvwb_pkg::SUM_W-1:0]   span;
   logic [ADDR_BITS-1:0]         addr_sh;
   lvwb_pkg::lvwb_job_ctl_type   ctl_new;
   logic [TAG_W-1:0]             tag_new;
   logic                         push;

   // Two-entry queue
   logic [TAG_W-1:0]           tag_ff [2];
   lvwb_pkg::lvwb_job_ctl_type ctl_ff [2];
   logic                       wr_ptr_ff, wr_ptr_in;
   logic                       rd_ptr_ff, rd_ptr_in;
   logic [1:0]                 count_ff, count_in;

   always_comb begin
      if (req_access_bytes == '0) begin
         bytes_n = lvwb_pkg::BYTES_W'(1);
      end else if (req_access_bytes > lvwb_pkg::BYTES_W'(lvwb_pkg::MAX_ACCESS_BYTES)) begin
         bytes_n = lvwb_pkg::BYTES_W'(lvwb_pkg::MAX_ACCESS_BYTES);
      end else begin
         bytes_n = req_access_bytes;
      end
      off              = req_addr[lvwb_pkg::OFF_W-1:0] & ~({lvwb_pkg::OFF_W{1'b1}} << lg_eff);
      span             = {1'b0, off} + {1'b0, bytes_n} - lvwb_pkg::SUM_W'(1);
      ctl_new.lines_m1 = lvwb_pkg::CNT_W'(span >> lg_eff);
      ctl_new.store    = req_func;
      addr_sh          = req_addr >> lg_eff;
      tag_new          = addr_sh[TAG_W-1:0];
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid & ~req_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ job_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, job_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         tag_ff[wr_ptr_ff] <= tag_new;
         ctl_ff[wr_ptr_ff] <= ctl_new;
      end
   end

   assign job_hs.valid = (count_ff != 2'd0);
   assign job_hs.ctl   = ctl_ff[rd_ptr_ff];
   assign job_tag      = tag_ff[rd_ptr_ff];

endmodule

[src/lvwb_back.sv]
module lvwb_back #(
   parameter int MAX_ENTRIES = lvwb_pkg::MAX_ENTRIES_DEF,
   parameter int ADDR_BITS   = lvwb_pkg::ADDR_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lvwb_pkg::lvwb_job_hs_type             job_hs,
   input  logic [ADDR_BITS-lvwb_pkg::LG_MIN-1:0] job_tag,
   output logic                                  job_pop,
   input  logic [lvwb_pkg::LG_W-1:0]             lg_eff,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0]      cap,
   input  logic                                  flush,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ADDR_BITS-1:0]                  rsp_line_addr,
   output logic                                  rsp_hit,
   output logic                                  rsp_fill_read,
   output logic                                  rsp_wb_valid,
   output logic [ADDR_BITS-1:0]                  rsp_wb_addr,
   output logic                                  rsp_last,
   output logic [lvwb_pkg::STAT_W-1:0]           rsp_read_hits,
   output logic [lvwb_pkg::STAT_W-1:0]           rsp_read_misses,
   output logic [lvwb_pkg::STAT_W-1:0]           rsp_write_hits,
   output logic [lvwb_pkg::STAT_W-1:0]           rsp_write_misses,
   output logic [lvwb_pkg::STAT_W-1:0]           rsp_writebacks
);

   localparam int TAG_W = ADDR_BITS - lvwb_pkg::LG_MIN;
   localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   function automatic logic [ADDR_BITS-1:0] line_of(input logic [TAG_W-1:0] t,
                                                   input logic [lvwb_pkg::LG_W-1:0] lg);
      logic [ADDR_BITS-1:0] w;
      w = {t, 2'b00};
      line_of = w << (lg - lvwb_pkg::LG_W'(lvwb_pkg::LG_MIN));
   endfunction

   // Tag store in recency order, entry 0 most recent
   logic [TAG_W-1:0]             tags_ff [MAX_ENTRIES];
   logic [OCC_W-1:0]             occ_ff, occ_in;

   // Line walker
   logic                         busy_ff, busy_in;
   logic                         store_ff, store_in;
   logic [TAG_W-1:0]             tag_ff, tag_in;
   logic [lvwb_pkg::CNT_W-1:0]   remain_ff, remain_in;

   logic [lvwb_pkg::STAT_W-1:0]  rd_hit_ff, rd_hit_in;
   logic [lvwb_pkg::STAT_W-1:0]  rd_miss_ff, rd_miss_in;
   logic [lvwb_pkg::STAT_W-1:0]  wr_hit_ff, wr_hit_in;
   logic [lvwb_pkg::STAT_W-1:0]  wr_miss_ff, wr_miss_in;
   logic [lvwb_pkg::STAT_W-1:0]  wb_cnt_ff, wb_cnt_in;

   logic                         out_valid_ff, out_valid_in;
   logic [ADDR_BITS-1:0]         out_line_ff;
   logic                         out_hit_ff;
   logic                         out_wb_ff;
   logic [ADDR_BITS-1:0]         out_wb_addr_ff;
   logic                         out_last_ff;

   logic                         process;
   logic [MAX_ENTRIES-1:0]       match;
   logic                         hit;
   logic [IDX_W-1:0]             pos;
   logic                         store_miss;
   logic                         evict;
   logic [OCC_W-1:0]             occ_m1;
   logic [TAG_W-1:0]             victim;
   logic [MAX_ENTRIES-1:0]       shift_en;
   logic [TAG_W-1:0]             tag_mask;

   assign process = busy_ff & (~out_valid_ff | ~rsp_stall);

   always_comb begin
      match = '0;
      pos   = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match[i] = (OCC_W'(i) < occ_ff) && (tags_ff[i] == tag_ff);
      end
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            pos = IDX_W'(i);
         end
      end
      hit        = |match;
      store_miss = ~hit & store_ff;
      evict      = store_miss & (occ_ff >= cap);
      occ_m1     = occ_ff - OCC_W'(1);
      victim     = tags_ff[occ_m1[IDX_W-1:0]];
      shift_en   = '0;
      for (int i = 1; i < MAX_ENTRIES; i++) begin
         shift_en[i] = hit ? (IDX_W'(i) <= pos) : store_miss;
      end
      tag_mask   = {TAG_W{1'b1}} >> (lg_eff - lvwb_pkg::LG_W'(lvwb_pkg::LG_MIN));
   end

   // Walk the lines of the current access; take the next one as the last line leaves
   always_comb begin
      job_pop   = job_hs.valid & (~busy_ff | (process & (remain_ff == '0)));
      busy_in   = busy_ff;
      store_in  = store_ff;
      tag_in    = tag_ff;
      remain_in = remain_ff;
      if (process) begin
         tag_in    = (tag_ff + TAG_W'(1)) & tag_mask;
         remain_in = remain_ff - lvwb_pkg::CNT_W'(1);
         if (remain_ff == '0) begin
            busy_in = 1'b0;
         end
      end
      if (job_pop) begin
         busy_in   = 1'b1;
         store_in  = job_hs.ctl.store;
         tag_in    = job_tag;
         remain_in = job_hs.ctl.lines_m1;
      end
   end

   always_comb begin
      occ_in     = occ_ff;
      rd_hit_in  = rd_hit_ff;
      rd_miss_in = rd_miss_ff;
      wr_hit_in  = wr_hit_ff;
      wr_miss_in = wr_miss_ff;
      wb_cnt_in  = wb_cnt_ff;
      if (process) begin
         if (hit) begin
            if (store_ff) begin
               wr_hit_in = lvwb_pkg::sat_inc(wr_hit_ff);
            end else begin
               rd_hit_in = lvwb_pkg::sat_inc(rd_hit_ff);
            end
         end else if (store_ff) begin
            wr_miss_in = lvwb_pkg::sat_inc(wr_miss_ff);
            if (evict) begin
               wb_cnt_in = lvwb_pkg::sat_inc(wb_cnt_ff);
            end else begin
               occ_in = occ_ff + OCC_W'(1);
            end
         end else begin
            rd_miss_in = lvwb_pkg::sat_inc(rd_miss_ff);
         end
      end
      if (flush) begin
         occ_in = '0;
      end
      out_valid_in = process | (out_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         rd_hit_ff    <= '0;
         rd_miss_ff   <= '0;
         wr_hit_ff    <= '0;
         wr_miss_ff   <= '0;
         wb_cnt_ff    <= '0;
      end else begin
         occ_ff       <= occ_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         rd_hit_ff    <= rd_hit_in;
         rd_miss_ff   <= rd_miss_in;
         wr_hit_ff    <= wr_hit_in;
         wr_miss_ff   <= wr_miss_in;
         wb_cnt_ff    <= wb_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff  <= store_in;
      tag_ff    <= tag_in;
      remain_ff <= remain_in;
   end

   // Move to front on hit, push in at front on store miss
   always_ff @(posedge clock) begin
      if (process & (hit | store_miss)) begin
         tags_ff[0] <= tag_ff;
         for (int i = 1; i < MAX_ENTRIES; i++) begin
            if (shift_en[i]) begin
               tags_ff[i] <= tags_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         out_line_ff    <= line_of(tag_ff, lg_eff);
         out_hit_ff     <= hit;
         out_wb_ff      <= evict;
         out_wb_addr_ff <= evict ? line_of(victim, lg_eff) : '0;
         out_last_ff    <= (remain_ff == '0);
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_line_addr    = out_line_ff;
   assign rsp_hit          = out_hit_ff;
   assign rsp_fill_read    = ~out_hit_ff;
   assign rsp_wb_valid     = out_wb_ff;
   assign rsp_wb_addr      = out_wb_addr_ff;
   assign rsp_last         = out_last_ff;
   assign rsp_read_hits    = rd_hit_ff;
   assign rsp_read_misses  = rd_miss_ff;
   assign rsp_write_hits   = wr_hit_ff;
   assign rsp_write_misses = wr_miss_ff;
   assign rsp_writebacks   = wb_cnt_ff;

endmodule

[src/lru_victim_write_buffer.sv]
// Channel  Direction  Handshake            Beat contents
// req_     in         req_valid/req_stall  addr, access_bytes, func
// rsp_     out        rsp_valid/rsp_stall  one line result plus running counters
// csr_     in         csr_valid/csr_ready  register index, write data
//
// One rsp beat leaves per touched line, one per cycle while rsp_stall is low; the
// first line of an access passes the queue write, the line walker registers and
// then the tag lookup into the output register.
// A two-entry queue decouples the front, so req beats are taken while the back
// walks lines or waits on rsp_stall. Reset is synchronous; the buffer starts
// empty, counters zero, entries_in_use 8, line_size_log2 6. csr_ready is
// always high; a write to either register empties the buffer and keeps the counters.
module lru_victim_write_buffer #(
   parameter int MAX_ENTRIES = lvwb_pkg::MAX_ENTRIES_DEF,
   parameter int ADDR_BITS   = lvwb_pkg::ADDR_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request beats
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ADDR_BITS-1:0]                 req_addr,
   input  logic [lvwb_pkg::BYTES_W-1:0]         req_access_bytes,
   input  logic                                 req_func,
   // result beats
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ADDR_BITS-1:0]                 rsp_line_addr,
   output logic                                 rsp_hit,
   output logic                                 rsp_fill_read,
   output logic                                 rsp_wb_valid,
   output logic [ADDR_BITS-1:0]                 rsp_wb_addr,
   output logic                                 rsp_last,
   output logic [lvwb_pkg::STAT_W-1:0]          rsp_read_hits,
   output logic [lvwb_pkg::STAT_W-1:0]          rsp_read_misses,
   output logic [lvwb_pkg::STAT_W-1:0]          rsp_write_hits,
   output logic [lvwb_pkg::STAT_W-1:0]          rsp_write_misses,
   output logic [lvwb_pkg::STAT_W-1:0]          rsp_writebacks,
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lvwb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lvwb_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int TAG_W = ADDR_BITS - lvwb_pkg::LG_MIN;
   localparam int OCC_W = $clog2(MAX_ENTRIES + 1);

   logic [lvwb_pkg::ENT_W-1:0] entries_ff, entries_in;
   logic [lvwb_pkg::LG_W-1:0]  lg_ff, lg_in;
   logic                       csr_wr;
   logic                       flush;
   logic [lvwb_pkg::LG_W-1:0]  lg_eff;
   logic [OCC_W-1:0]           cap;

   lvwb_pkg::lvwb_job_hs_type  job_hs;
   logic [TAG_W-1:0]           job_tag;
   logic                       job_pop;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   // Decode the write; unknown indexes leave everything alone
   always_comb begin
      entries_in = entries_ff;
      lg_in      = lg_ff;
      flush      = 1'b0;
      if (csr_wr) begin
         case (csr_index)
            lvwb_pkg::CSR_ENTRIES_IN_USE: begin
               entries_in = csr_wdata[lvwb_pkg::ENT_W-1:0];
               flush      = 1'b1;
            end
            lvwb_pkg::CSR_LINE_SIZE_LOG2: begin
               lg_in = csr_wdata[lvwb_pkg::LG_W-1:0];
               flush = 1'b1;
            end
            default: begin
               flush = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= lvwb_pkg::ENT_W'(8);
         lg_ff      <= lvwb_pkg::LG_W'(6);
      end else begin
         entries_ff <= entries_in;
         lg_ff      <= lg_in;
      end
   end

   // Clamp line size up to four bytes and the entry limit into 1..MAX_ENTRIES
   always_comb begin
      lg_eff = (lg_ff < lvwb_pkg::LG_W'(lvwb_pkg::LG_MIN)) ?
               lvwb_pkg::LG_W'(lvwb_pkg::LG_MIN) : lg_ff;
      if (entries_ff == '0) begin
         cap = OCC_W'(1);
      end else if (32'(entries_ff) > MAX_ENTRIES) begin
         cap = OCC_W'(MAX_ENTRIES);
      end else begin
         cap = OCC_W'(entries_ff);
      end
   end

   lvwb_front #(
      .ADDR_BITS (ADDR_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_addr         (req_addr),
      .req_access_bytes (req_access_bytes),
      .req_func         (req_func),
      .lg_eff           (lg_eff),
      .job_hs           (job_hs),
      .job_tag          (job_tag),
      .job_pop          (job_pop)
   );

   lvwb_back #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .ADDR_BITS   (ADDR_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .job_hs           (job_hs),
      .job_tag          (job_tag),
      .job_pop          (job_pop),
      .lg_eff           (lg_eff),
      .cap              (cap),
      .flush            (flush),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_addr    (rsp_line_addr),
      .rsp_hit          (rsp_hit),
      .rsp_fill_read    (rsp_fill_read),
      .rsp_wb_valid     (rsp_wb_valid),
      .rsp_wb_addr      (rsp_wb_addr),
      .rsp_last         (rsp_last),
      .rsp_read_hits    (rsp_read_hits),
      .rsp_read_misses  (rsp_read_misses),
      .rsp_write_hits   (rsp_write_hits),
      .rsp_write_misses (rsp_write_misses),
      .rsp_writebacks   (rsp_writebacks)
   );

endmodule
